// ===== hw/rtl/multicore_fifo_dispatcher_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the FIFO dispatcher
// Clock aclk and active-low reset aresetn are taken from the using scope.
// ----------------------------------------------------------------------------
`ifndef MULTICORE_FIFO_DISPATCHER_UNIT_ASSERT_SVH
`define MULTICORE_FIFO_DISPATCHER_UNIT_ASSERT_SVH

// Same-cycle implication
`define MFD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define MFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared types, codes and defaults of the FIFO dispatcher.
// ----------------------------------------------------------------------------
package mfd_pkg;

    localparam int CPU_FIELD_W  = 3;
    localparam int TASK_FIELD_W = 8;
    localparam int QCOUNT_W     = 7;
    localparam int RR_W         = 10;
    localparam int ACTIVE_W     = 8;
    localparam int CPU_SPAN     = 8;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 10;

    localparam int DEF_NUM_CPUS     = 8;
    localparam int DEF_QUEUE_DEPTH  = 64;
    localparam int DEF_TASK_ID_BITS = 8;

    localparam logic [RR_W-1:0]     RR_RESET     = 10'd5;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 8'hFF;

    // Item kinds
    localparam logic [2:0] KIND_ENQUEUE = 3'd0;
    localparam logic [2:0] KIND_ACQUIRE = 3'd1;
    localparam logic [2:0] KIND_RELEASE = 3'd2;
    localparam logic [2:0] KIND_TICK    = 3'd3;
    localparam logic [2:0] KIND_YIELD   = 3'd4;
    localparam logic [2:0] KIND_HELPER  = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_RR_INTERVAL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CPU_ACTIVE  = 2'd1;

    typedef struct packed {
        logic [2:0]              kind;
        logic [CPU_FIELD_W-1:0]  cpu;
        logic [TASK_FIELD_W-1:0] task_id;
        logic                    task_running;
    } mfd_item_t;

    typedef struct packed {
        logic                    assign_valid;
        logic [TASK_FIELD_W-1:0] assign_task;
        logic                    wake_valid;
        logic [CPU_FIELD_W-1:0]  wake_cpu;
        logic                    granted;
        logic                    dropped;
        logic [QCOUNT_W-1:0]     queue_count;
        logic                    cpu_idle;
    } mfd_result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic commit;
        logic cfg_we;
    } mfd_cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mfd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfd_ctrl
// Handshake controller: capture, execute and result register valid.
// ----------------------------------------------------------------------------
module mfd_ctrl
    import mfd_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    input  wire logic cfg_valid,
    output logic      cfg_ready,
    output mfd_cmd_t  cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;

    assign s_ready     = (state_reg == ST_IDLE);
    assign cfg_ready   = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign cmd.capture = s_valid && s_ready;
    assign cmd.commit  = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);
    assign cmd.cfg_we  = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (cmd.capture) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (cmd.commit) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/mfd_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfd_datapath
// Run queue memory, per-CPU slots and counters, dispatch logic, result register.
// ----------------------------------------------------------------------------
module mfd_datapath
    import mfd_pkg::*;
#(
    parameter int NUM_CPUS     = DEF_NUM_CPUS,
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
    parameter int TASK_ID_BITS = DEF_TASK_ID_BITS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire mfd_cmd_t               cmd,
    input  wire mfd_item_t              s_data,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output mfd_result_t                 m_data
);

    // Only CPUs that the cpu field can name take part
    localparam int LIVE_CPUS = (NUM_CPUS < CPU_SPAN) ? NUM_CPUS : CPU_SPAN;
    localparam int CIW       = $clog2(LIVE_CPUS);
    localparam int QIW       = $clog2(QUEUE_DEPTH);
    localparam int QLW       = $clog2(QUEUE_DEPTH + 1);
    localparam int TB        = TASK_ID_BITS;

    localparam logic [CPU_FIELD_W:0] LIVE_CNT   = (CPU_FIELD_W + 1)'(LIVE_CPUS);
    localparam logic [QLW-1:0]       QUEUE_FULL = QLW'(QUEUE_DEPTH);
    localparam logic [QIW-1:0]       PTR_LAST   = QIW'(QUEUE_DEPTH - 1);

    mfd_item_t              item_reg;
    logic [TB-1:0]          mem [QUEUE_DEPTH];
    logic [TB-1:0]          rd_data_reg;
    logic [QIW-1:0]         head_reg, head_next;
    logic [QIW-1:0]         tail_reg, tail_next;
    logic [QLW-1:0]         len_reg, len_next;
    logic [RR_W-1:0]        rr_reg;
    logic [ACTIVE_W-1:0]    active_reg;
    logic [LIVE_CPUS-1:0]   ready_reg, ready_next;
    logic [LIVE_CPUS-1:0]   slot_full_reg;
    logic [TB-1:0]          slot_task_reg [LIVE_CPUS];
    logic [RR_W-1:0]        tick_reg [LIVE_CPUS];
    logic [LIVE_CPUS-1:0]   resched_reg;
    mfd_result_t            out_reg, out_next;

    logic [LIVE_CPUS-1:0]   active_vec;
    logic [LIVE_CPUS-1:0]   busy_vec;
    logic [LIVE_CPUS-1:0]   self_bit;
    logic [LIVE_CPUS-1:0]   wake_mask;
    logic [CIW-1:0]         cidx;
    logic                   in_range;
    logic                   ok;
    logic [TB+TASK_FIELD_W-1:0] task_ext;
    logic [TB-1:0]          item_task;
    logic                   full0, full_next;
    logic [TB-1:0]          task0, task_next;
    logic                   resched_next;
    logic [RR_W-1:0]        tick_next;
    logic [RR_W:0]          tick_sum;
    logic                   pop, try_push, push, do_wake;
    logic                   wake_found;
    logic [CIW-1:0]         wake_idx;
    logic [QLW-1:0]         len_pop;
    logic                   av, wv, gr, dr;
    logic [TB+TASK_FIELD_W-1:0] out_task_ext;
    logic [QLW+QCOUNT_W-1:0]    count_ext;

    assign active_vec = active_reg[LIVE_CPUS-1:0];
    assign busy_vec   = ~active_vec | slot_full_reg;
    assign in_range   = {1'b0, item_reg.cpu} < LIVE_CNT;
    assign cidx       = item_reg.cpu[CIW-1:0];
    assign ok         = in_range && active_vec[cidx];
    assign self_bit   = LIVE_CPUS'(1) << cidx;
    assign task_ext   = {{TB{1'b0}}, item_reg.task_id};
    assign item_task  = task_ext[TB-1:0];
    assign full0      = slot_full_reg[cidx];
    assign task0      = slot_task_reg[cidx];

    always_comb begin
        full_next    = full0;
        task_next    = task0;
        resched_next = resched_reg[cidx];
        tick_next    = tick_reg[cidx];
        tick_sum     = {1'b0, tick_reg[cidx]} + 1'b1;
        ready_next   = ready_reg;
        pop          = 1'b0;
        try_push     = 1'b0;
        push         = 1'b0;
        do_wake      = 1'b0;
        av           = 1'b0;
        wv           = 1'b0;
        gr           = 1'b0;
        dr           = 1'b0;

        if (ok) begin
            unique case (item_reg.kind)
                KIND_ENQUEUE: begin
                    if (!full0) begin
                        full_next = 1'b1;
                        task_next = item_task;
                        av        = 1'b1;
                    end else begin
                        try_push = 1'b1;
                    end
                end
                KIND_ACQUIRE: begin
                    // pending reschedule: select before the grant check
                    if (resched_reg[cidx]) begin
                        resched_next = 1'b0;
                        if (len_reg != '0) begin
                            pop       = 1'b1;
                            full_next = 1'b1;
                            task_next = rd_data_reg;
                            av        = 1'b1;
                        end else begin
                            full_next = 1'b0;
                        end
                    end
                    if (!full_next || task_next == item_task) begin
                        full_next = 1'b1;
                        task_next = item_task;
                        av        = 1'b1;
                        gr        = 1'b1;
                    end else begin
                        try_push = 1'b1;
                    end
                end
                KIND_RELEASE: begin
                    if (full0 && task0 == item_task) begin
                        resched_next = 1'b0;
                        if (len_reg != '0) begin
                            pop       = 1'b1;
                            task_next = rd_data_reg;
                            av        = 1'b1;
                        end else begin
                            full_next = 1'b0;
                        end
                    end
                end
                KIND_TICK: begin
                    if (item_reg.task_running) begin
                        if (tick_sum >= {1'b0, rr_reg}) begin
                            tick_sum     = '0;
                            resched_next = 1'b1;
                        end
                        tick_next = tick_sum[RR_W-1:0];
                    end
                end
                KIND_YIELD: begin
                    resched_next = 1'b1;
                end
                KIND_HELPER: begin
                    ready_next[cidx] = 1'b1;
                    if (full0) begin
                        do_wake = (len_reg != '0);
                    end else if (len_reg != '0) begin
                        pop       = 1'b1;
                        full_next = 1'b1;
                        task_next = rd_data_reg;
                        av        = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        // Queue pointers: pop first, then push behind it
        len_pop   = pop ? len_reg - 1'b1 : len_reg;
        head_next = pop ? ((head_reg == PTR_LAST) ? '0 : head_reg + 1'b1) : head_reg;
        tail_next = tail_reg;
        len_next  = len_pop;
        if (try_push) begin
            if (len_pop == QUEUE_FULL) begin
                dr = 1'b1;
            end else begin
                push      = 1'b1;
                tail_next = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
                len_next  = len_pop + 1'b1;
                do_wake   = 1'b1;
            end
        end

        // Wake the lowest ready idle CPU other than this one
        wake_mask  = ready_next & ~busy_vec & ~self_bit;
        wake_found = 1'b0;
        wake_idx   = '0;
        for (int i = LIVE_CPUS - 1; i >= 0; i--) begin
            if (wake_mask[i]) begin
                wake_found = 1'b1;
                wake_idx   = CIW'(i);
            end
        end
        if (do_wake && wake_found) begin
            ready_next[wake_idx] = 1'b0;
            wv                   = 1'b1;
        end

        out_task_ext          = {{TASK_FIELD_W{1'b0}}, task_next};
        count_ext             = {{QCOUNT_W{1'b0}}, len_next};
        out_next.assign_valid = av;
        out_next.assign_task  = av ? out_task_ext[TASK_FIELD_W-1:0] : '0;
        out_next.wake_valid   = wv;
        out_next.wake_cpu     = wv ? CPU_FIELD_W'(wake_idx) : '0;
        out_next.granted      = gr;
        out_next.dropped      = dr;
        out_next.queue_count  = count_ext[QCOUNT_W-1:0];
        out_next.cpu_idle     = in_range ? !full_next : 1'b1;
    end

    // Run queue memory: head read on capture, tail write on commit
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            rd_data_reg <= mem[head_reg];
        end
        if (cmd.commit && push) begin
            mem[tail_reg] <= item_task;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_data;
        end
        if (cmd.commit) begin
            slot_task_reg[cidx] <= task_next;
            out_reg             <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            len_reg       <= '0;
            rr_reg        <= RR_RESET;
            active_reg    <= ACTIVE_RESET;
            ready_reg     <= ACTIVE_RESET[LIVE_CPUS-1:0];
            slot_full_reg <= '0;
            resched_reg   <= '0;
            tick_reg      <= '{default: '0};
        end else if (cmd.commit) begin
            head_reg            <= head_next;
            tail_reg            <= tail_next;
            len_reg             <= len_next;
            ready_reg           <= ready_next;
            slot_full_reg[cidx] <= full_next;
            resched_reg[cidx]   <= resched_next;
            tick_reg[cidx]      <= tick_next;
        end else if (cmd.cfg_we) begin
            if (cfg_index == REG_RR_INTERVAL) begin
                rr_reg <= cfg_data[RR_W-1:0];
            end else if (cfg_index == REG_CPU_ACTIVE) begin
                active_reg <= cfg_data[ACTIVE_W-1:0];
                // drop ready on CPUs leaving dispatch
                ready_reg  <= ready_reg & cfg_data[LIVE_CPUS-1:0];
            end
        end
    end

    assign m_data = out_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/multicore_fifo_dispatcher_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multicore_fifo_dispatcher_unit
// Global FIFO run queue dispatcher for a small multicore cluster.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake             Payload
//  s_       in   s_valid / s_ready     s_data   (mfd_item_t: kind, cpu, task)
//  m_       out  m_valid / m_ready     m_data   (mfd_result_t, one per item)
//  cfg_     in   cfg_valid / cfg_ready cfg_index, cfg_data
//
//  Each item passes a transfer state and then an execute state: the transfer
//  reads the run queue head from its memory, the execute state computes and
//  writes back state, the queue tail and the result register. The single
//  memory port pair sets this. The execute cycle waits while the result
//  register holds an untaken result; a new item is taken while a result
//  waits. Reset is synchronous; the queue memory needs no clearing pass.
//
`include "multicore_fifo_dispatcher_unit_assert.svh"

module multicore_fifo_dispatcher_unit
    import mfd_pkg::*;
#(
    parameter int NUM_CPUS     = DEF_NUM_CPUS,
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
    parameter int TASK_ID_BITS = DEF_TASK_ID_BITS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire mfd_item_t              s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output mfd_result_t                 m_data,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    // Commands from the controller drive every datapath register update
    mfd_cmd_t cmd;

    // Controller: sequences capture and execute, owns the result valid
    mfd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    // Datapath: run queue, per-CPU slots, masks and the result register
    mfd_datapath #(
        .NUM_CPUS     (NUM_CPUS),
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .TASK_ID_BITS (TASK_ID_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_data    (s_data),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_data    (m_data)
    );

    // An accepted item holds off further transfers during its execute state
    `MFD_ASSERT_NEXT(a_accept_blocks, s_valid && s_ready, !s_ready && !cfg_ready, "accept not followed by execute")
    // Execution always presents a result in the next cycle
    `MFD_ASSERT_NEXT(a_commit_result, cmd.commit, m_valid, "commit did not raise m_valid")
    // Never overwrite a result that has not been taken
    `MFD_ASSERT_NOW(a_no_overwrite, cmd.commit, !m_valid || m_ready, "result overwritten")
    // Configuration never lands while an item executes
    `MFD_ASSERT_NOW(a_cfg_idle, cfg_valid && cfg_ready, !cmd.commit, "config during execute")

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: FIFO dispatcher testbench
// Drives scheduler events into the dispatcher and checks every result
// against an in-bench model of the run queue, the per-CPU slots and the
// busy/ready masks. The bench runs a directed opening and then several
// register settings with random events. It also runs queue floods, a stretch
// with no idling, and a long receiver stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_top;
    import mfd_pkg::*;

    // Kinds the block must ignore
    localparam logic [2:0] KIND_SPARE_A = 3'd6;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;

    localparam int NCPU  = DEF_NUM_CPUS;
    localparam int DEPTH = DEF_QUEUE_DEPTH;

    // Register settings per phase: extremes of both registers, plus zero interval
    localparam logic [RR_W-1:0]     PHASE_RR     [8] = '{10'd1, 10'd1023, 10'd0, 10'd3,
                                                         10'd7, 10'd2, 10'd1, 10'd12};
    localparam logic [ACTIVE_W-1:0] PHASE_ACTIVE [8] = '{8'hFF, 8'h0F, 8'hA5, 8'h00,
                                                         8'h81, 8'hFF, 8'h7E, 8'hC3};

    class dispatch_scoreboard;
        logic [RR_W-1:0]         rr_interval;
        logic [ACTIVE_W-1:0]     cpu_active;
        logic [TASK_FIELD_W-1:0] run_q [DEPTH];
        int unsigned             q_head;
        int unsigned             q_tail;
        int unsigned             q_len;
        logic [TASK_FIELD_W:0]   slot [NCPU];     // msb: slot filled
        logic [NCPU-1:0]         busy_mask;
        logic [NCPU-1:0]         ready_mask;
        logic [RR_W-1:0]         tick_cnt [NCPU];
        bit                      resched [NCPU];
        mfd_result_t             expected_results [$];
        int unsigned             errors;

        function new();
            rr_interval = RR_RESET;
            cpu_active  = ACTIVE_RESET;
            q_head      = 0;
            q_tail      = 0;
            q_len       = 0;
            busy_mask   = ~ACTIVE_RESET;
            ready_mask  = ACTIVE_RESET;
            errors      = 0;
            for (int c = 0; c < NCPU; c++) begin
                slot[c]     = '0;
                tick_cnt[c] = '0;
                resched[c]  = 1'b0;
            end
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_RR_INTERVAL) begin
                rr_interval = data[RR_W-1:0];
            end else if (idx == REG_CPU_ACTIVE) begin
                cpu_active = data[ACTIVE_W-1:0];
                for (int c = 0; c < NCPU; c++) begin
                    busy_mask[c] = !cpu_active[c] || slot[c][TASK_FIELD_W];
                    if (!cpu_active[c]) ready_mask[c] = 1'b0;
                end
            end
        endfunction

        function logic [TASK_FIELD_W-1:0] pop_head();
            logic [TASK_FIELD_W-1:0] t;
            t      = run_q[q_head];
            q_head = (q_head + 1) % DEPTH;
            q_len--;
            return t;
        endfunction

        // Pop the head into the CPU's slot, or empty the slot when nothing waits
        function bit select_on(int unsigned c);
            resched[c] = 1'b0;
            if (q_len == 0) begin
                slot[c]      = '0;
                busy_mask[c] = 1'b0;
                return 1'b0;
            end
            slot[c]      = {1'b1, pop_head()};
            busy_mask[c] = 1'b1;
            return 1'b1;
        endfunction

        // Signal the lowest ready, idle CPU other than c
        function void wake_other(int unsigned c, inout mfd_result_t r);
            logic [NCPU-1:0] m;
            m = ready_mask & ~busy_mask;
            m[c] = 1'b0;
            for (int i = 0; i < NCPU; i++) begin
                if (m[i]) begin
                    ready_mask[i] = 1'b0;
                    r.wake_valid  = 1'b1;
                    r.wake_cpu    = CPU_FIELD_W'(i);
                    return;
                end
            end
        endfunction

        // Run the task at once on an idle CPU, else queue it (or drop when full)
        function bit run_or_queue(int unsigned c, logic [TASK_FIELD_W-1:0] tid,
                                  inout mfd_result_t r);
            if (!slot[c][TASK_FIELD_W]) begin
                slot[c]      = {1'b1, tid};
                busy_mask[c] = 1'b1;
                return 1'b1;
            end
            if (q_len >= DEPTH) begin
                r.dropped = 1'b1;
                return 1'b0;
            end
            run_q[q_tail] = tid;
            q_tail        = (q_tail + 1) % DEPTH;
            q_len++;
            wake_other(c, r);
            return 1'b0;
        endfunction

        function void note_item(mfd_item_t it);
            mfd_result_t r;
            int unsigned c;
            int unsigned n;
            r = '0;
            c = it.cpu;
            if (cpu_active[c]) begin
                case (it.kind)
                    KIND_ENQUEUE: begin
                        r.assign_valid = run_or_queue(c, it.task_id, r);
                    end
                    KIND_ACQUIRE: begin
                        if (resched[c]) begin
                            if (select_on(c)) r.assign_valid = 1'b1;
                        end
                        if (slot[c] == {1'b1, it.task_id} || !slot[c][TASK_FIELD_W]) begin
                            slot[c]        = {1'b1, it.task_id};
                            busy_mask[c]   = 1'b1;
                            r.assign_valid = 1'b1;
                            r.granted      = 1'b1;
                        end else begin
                            void'(run_or_queue(c, it.task_id, r));
                        end
                    end
                    KIND_RELEASE: begin
                        if (slot[c] == {1'b1, it.task_id}) begin
                            if (select_on(c)) r.assign_valid = 1'b1;
                        end
                    end
                    KIND_TICK: begin
                        if (it.task_running) begin
                            n = tick_cnt[c] + 1;
                            if (n >= rr_interval) begin
                                n          = 0;
                                resched[c] = 1'b1;
                            end
                            tick_cnt[c] = n[RR_W-1:0];
                        end
                    end
                    KIND_YIELD: begin
                        resched[c] = 1'b1;
                    end
                    KIND_HELPER: begin
                        ready_mask[c] = 1'b1;
                        if (slot[c][TASK_FIELD_W]) begin
                            if (q_len != 0) wake_other(c, r);
                        end else if (q_len != 0) begin
                            slot[c]        = {1'b1, pop_head()};
                            busy_mask[c]   = 1'b1;
                            r.assign_valid = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            r.assign_task = r.assign_valid ? slot[c][TASK_FIELD_W-1:0] : '0;
            r.queue_count = QCOUNT_W'(q_len);
            r.cpu_idle    = !slot[c][TASK_FIELD_W];
            expected_results.push_back(r);
        endfunction

        function void cmp_field(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(mfd_result_t got);
            mfd_result_t e;
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing pending");
                errors++;
                return;
            end
            e = expected_results.pop_front();
            cmp_field("assign_valid", e.assign_valid, got.assign_valid);
            cmp_field("assign_task",  e.assign_task,  got.assign_task);
            cmp_field("wake_valid",   e.wake_valid,   got.wake_valid);
            cmp_field("wake_cpu",     e.wake_cpu,     got.wake_cpu);
            cmp_field("granted",      e.granted,      got.granted);
            cmp_field("dropped",      e.dropped,      got.dropped);
            cmp_field("queue_count",  e.queue_count,  got.queue_count);
            cmp_field("cpu_idle",     e.cpu_idle,     got.cpu_idle);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block's pins; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    mfd_item_t              s_data    = '0;
    logic                   m_ready   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_ready;
    logic                   m_valid;
    mfd_result_t            m_data;
    logic                   cfg_ready;

    dispatch_scoreboard sb;

    bit          full_speed    = 1'b0;   // both sides stop idling
    int unsigned pressure_asks = 0;      // bumped by stimulus to request a long stall
    int unsigned pressure_seen = 0;      // receiver's copy of the request count
    int unsigned hold_left     = 0;

    always #1 aclk = ~aclk;

    multicore_fifo_dispatcher_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Result side: check each transfer, then pick next cycle's ready.
    // A pressure request holds ready low for a long stretch so the result
    // register fills and the input channel stalls behind it.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (pressure_seen != pressure_asks) begin
            pressure_seen <= pressure_asks;
            hold_left     <= 400;
            m_ready       <= 1'b0;
        end else begin
            m_ready <= full_speed || ($urandom_range(0, 99) >= 20);
        end
    end

    // Hard stop in case a handshake never completes
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic mfd_item_t make_item(logic [2:0] k, int unsigned c, int unsigned tid,
                                            bit run);
        mfd_item_t it;
        it.kind         = k;
        it.cpu          = CPU_FIELD_W'(c);
        it.task_id      = TASK_FIELD_W'(tid);
        it.task_running = run;
        return it;
    endfunction

    // Draw a random event; mostly on active CPUs, releases mostly name the
    // task that is really current so the queue keeps draining
    function automatic mfd_item_t draw_item();
        mfd_item_t   it;
        int unsigned r;
        int unsigned c;
        r = $urandom_range(0, 99);
        c = $urandom_range(0, NCPU - 1);
        if (sb.cpu_active != 0 && $urandom_range(0, 99) < 85) begin
            while (!sb.cpu_active[c]) c = $urandom_range(0, NCPU - 1);
        end
        it = make_item(KIND_ENQUEUE, c, $urandom_range(0, 255), 1'($urandom_range(0, 1)));
        if (r < 28) begin
            it.kind = KIND_ENQUEUE;
        end else if (r < 42) begin
            it.kind = KIND_ACQUIRE;
            if ($urandom_range(0, 99) < 40) it.task_id = sb.slot[c][TASK_FIELD_W-1:0];
        end else if (r < 58) begin
            it.kind = KIND_RELEASE;
            if ($urandom_range(0, 99) < 75) it.task_id = sb.slot[c][TASK_FIELD_W-1:0];
        end else if (r < 72) begin
            it.kind         = KIND_TICK;
            it.task_running = ($urandom_range(0, 99) < 80);
        end else if (r < 80) begin
            it.kind = KIND_YIELD;
        end else if (r < 97) begin
            it.kind = KIND_HELPER;
        end else begin
            it.kind = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
        end
        return it;
    endfunction

    // Offer one item, idling first at random; valid stays high through stalls
    task automatic push_item(mfd_item_t it);
        while (!full_speed && $urandom_range(0, 99) < 20) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_item(it);
    endtask

    // Drop valid and wait until every pending result has been taken
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge aclk);
    endtask

    // Hold the write until it transfers, then drop valid for one full cycle
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned n_items;
        int unsigned c;
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening at reset settings (interval 5, all CPUs active)
        push_item(make_item(KIND_ENQUEUE, 0, 8'h00, 1'b0));  // idle CPU: runs at once
        push_item(make_item(KIND_ENQUEUE, 0, 8'hFF, 1'b1));  // busy: queue and wake
        push_item(make_item(KIND_ACQUIRE, 0, 8'h00, 1'b0));  // already current: granted
        push_item(make_item(KIND_ACQUIRE, 0, 8'h5A, 1'b0));  // other task: queued
        push_item(make_item(KIND_ENQUEUE, 0, 8'hFF, 1'b0));  // same task queued twice
        push_item(make_item(KIND_HELPER,  1, 8'h00, 1'b0));  // idle helper pulls head
        push_item(make_item(KIND_HELPER,  1, 8'h00, 1'b0));  // busy helper wakes another
        push_item(make_item(KIND_RELEASE, 0, 8'h01, 1'b0));  // wrong task: no effect
        push_item(make_item(KIND_RELEASE, 0, 8'h00, 1'b0));  // pops next task
        push_item(make_item(KIND_YIELD,   0, 8'h00, 1'b0));
        push_item(make_item(KIND_ACQUIRE, 0, 8'hA5, 1'b0));  // reschedule pending first
        push_item(make_item(KIND_TICK,    7, 8'hFF, 1'b0));  // no user task: not counted
        repeat (5) push_item(make_item(KIND_TICK, 2, 8'h00, 1'b1));  // reaches interval
        push_item(make_item(KIND_ACQUIRE, 2, 8'h33, 1'b0));
        push_item(make_item(KIND_SPARE_A, 7, 8'hFF, 1'b1));  // ignored kinds
        push_item(make_item(KIND_SPARE_B, 7, 8'hFF, 1'b1));
        push_item(make_item(KIND_HELPER,  7, 8'h00, 1'b0));
        push_item(make_item(KIND_RELEASE, 6, 8'h00, 1'b0));  // empty slot: no effect
        push_item(make_item(KIND_ACQUIRE, 6, 8'hFF, 1'b0));  // empty slot: granted
        drain();

        for (int p = 0; p < 8; p++) begin
            // Keep the block idle around register writes; upper data bits are junk
            write_reg(REG_RR_INTERVAL, PHASE_RR[p]);
            write_reg(REG_CPU_ACTIVE, {2'($urandom_range(0, 3)), PHASE_ACTIVE[p]});
            full_speed = (p == 5);
            if (p == 6) pressure_asks++;

            // Flood one active CPU until the queue overflows and drops
            if (p % 3 == 1) begin
                c = 0;
                while (!sb.cpu_active[c]) c++;
                repeat (68) push_item(make_item(KIND_ENQUEUE, c, $urandom_range(0, 255),
                                                1'($urandom_range(0, 1))));
            end

            n_items = (PHASE_ACTIVE[p] == '0) ? 40 : 240;
            repeat (n_items) push_item(draw_item());
            drain();
        end
        full_speed = 1'b0;

        // Allow stray results to show up before the verdict
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== multicore_fifo_dispatcher_unit.f =====
+incdir+hw/rtl
hw/rtl/mfd_pkg.sv
hw/rtl/mfd_ctrl.sv
hw/rtl/mfd_datapath.sv
hw/rtl/multicore_fifo_dispatcher_unit.sv
verif/tb_top.sv
